FILE: sv/gsm_pkg.sv
// Shared types and constants for the gyro stick mixer.
// Used by every module of the block; depends on nothing.
package gsm_pkg;

  localparam int FILT_W    = 24;    // filtered rate width
  localparam int STICK_W   = 16;    // stick axis width
  localparam int DZ_W      = 15;    // deadzone register width
  localparam int MUL_A_W   = 24;    // serial multiplier, bits consumed one per cycle
  localparam int ROOT_W    = 24;    // square root width
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int DIVISOR_W = 32;    // serial divider divisor width
  localparam int GAIN      = 22000; // output span of the mapped rate range
  localparam int FILT_DIV  = 5;     // low-pass filter divisor

  localparam logic REG_DEADZONE = 1'b0;

  typedef enum logic [1:0] {
    OP_STICK_X = 2'd0,
    OP_STICK_Y = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILT_YAW,
    ST_FILT_PITCH,
    ST_STICK_X,
    ST_STICK_Y,
    ST_DZ,
    ST_SQ_YAW,
    ST_SQ_PITCH,
    ST_SQRT,
    ST_NUM,
    ST_NUM_ADD,
    ST_MAG,
    ST_GX_MUL,
    ST_GX_DIV,
    ST_GY_MUL,
    ST_GY_DIV,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: sv/gyro_stick_mixer_unit.sv
// Top level of the gyro stick mixer: request sequencer, state and register port.
// Depends on gsm_pkg, gsm_mul, gsm_div and gsm_sqrt.
//
// Usage. Requests arrive on the s_axis channel; tuser carries the operation
// (stick x update, stick y update, gyro tick) and tdata the axis value and the
// yaw and pitch rates. A stick update is cached while idle and gives no
// result. A gyro tick filters both rates, takes the rate and stick magnitudes,
// scales the rate direction and mixes in the stick or the deadzone offset;
// its result leaves on m_axis with x in the low half of tdata.
// A tick runs through one shared bit-serial multiplier (eight products), one
// bit-serial divider (five quotients) and a two-bit-per-cycle square root.
// The five divisions dominate the time of a tick; at RATE_FRAC_BITS = 12 the
// divider's dividend is 53 bits wide. A zero rate magnitude skips the mapping.
// One request is worked on at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so the next request is accepted
// while a stalled receiver still holds the previous result; a tick that ends
// while that register is full waits until it drains.
// Reset clears the filters, the cached stick, the deadzone and the output
// valid. The user must write the deadzone register through the APB port only
// while idle; the block itself does not enforce it.
module gyro_stick_mixer_unit #(
  parameter int RATE_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // axis_value, yaw_rate, pitch_rate (from bit 0 up)
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // stick_out_x, stick_out_y (from bit 0 up)
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gsm_pkg::*;

  // The filtered rates carry S fraction bits.
  localparam int S      = RATE_FRAC_BITS + 8;
  localparam int NUM_W  = (S + 22 > 46) ? S + 22 : 46;
  localparam int MAG_W  = NUM_W - S + 3;
  localparam int MB_W   = (MAG_W > ROOT_W + 4) ? MAG_W : ROOT_W + 4;
  localparam int DIV_W  = MUL_A_W + MB_W;
  localparam int T_W    = ROOT_W + 5;
  localparam int X_W    = FILT_W + 3;
  localparam int MIX_W  = MAG_W + 2;
  localparam logic signed [T_W-1:0]   ONE_T       = T_W'(1) << S;
  localparam logic [DIVISOR_W-1:0]    MAG_DIVISOR = DIVISOR_W'(17) << (S - 8);
  localparam logic signed [MIX_W-1:0] SAT_HI      = MIX_W'(32767);
  localparam logic signed [MIX_W-1:0] SAT_LO      = -MIX_W'(32768);

  state_t state;
  state_t state_next;
  logic   launched;

  // Architectural state.
  logic signed [FILT_W-1:0]  fy;
  logic signed [FILT_W-1:0]  fp;
  logic signed [STICK_W-1:0] csx;
  logic signed [STICK_W-1:0] csy;
  logic [DZ_W-1:0]           dz;

  // Working registers of one tick.
  logic signed [STICK_W-1:0] yaw_in;
  logic signed [STICK_W-1:0] pitch_in;
  logic [31:0]               sq_sum;
  logic                      dead;
  logic [RAD_W-1:0]          rad;
  logic [ROOT_W-1:0]         root;
  logic signed [NUM_W-1:0]   num;
  logic [MAG_W-1:0]          mag;
  logic                      mag_neg;
  logic signed [MAG_W:0]     gx;
  logic signed [MAG_W:0]     gy;

  // Unit interfaces.
  logic                   mul_start;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MB_W-1:0]        mul_b;
  unit_stat_t             mul_stat;
  logic [DIV_W-1:0]       mul_p;
  logic                   div_start;
  logic [DIV_W-1:0]       div_n;
  logic [DIVISOR_W-1:0]   div_d;
  unit_stat_t             div_stat;
  logic [DIV_W-1:0]       div_q;
  logic                   sqrt_start;
  unit_stat_t             sqrt_stat;
  logic [ROOT_W-1:0]      sqrt_root;

  // Derived values.
  logic signed [X_W-1:0]     filt_sum;
  logic [X_W-1:0]            filt_mag;
  logic [FILT_W-1:0]         fy_abs;
  logic [FILT_W-1:0]         fp_abs;
  logic [STICK_W-1:0]        csx_abs;
  logic [STICK_W-1:0]        csy_abs;
  logic signed [T_W-1:0]     t_val;
  logic [T_W-2:0]            t_abs;
  logic [NUM_W-1:0]          num_abs;
  logic signed [NUM_W-1:0]   dz_term;
  logic signed [MIX_W-1:0]   mix_x;
  logic signed [MIX_W-1:0]   mix_y;
  logic [STICK_W-1:0]        sat_x;
  logic [STICK_W-1:0]        sat_y;
  logic                      cfg_write;

  gsm_mul #(.B_W(MB_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_stat),
    .product (mul_p)
  );

  gsm_div #(.DD_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .stat     (div_stat),
    .quotient (div_q)
  );

  gsm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (rad),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  // The low-pass step is (4 * old + 256 * rate) / 5, truncated toward zero.
  always_comb begin
    if (state == ST_FILT_PITCH) begin
      filt_sum = (X_W'(fp) <<< 2) + (X_W'(pitch_in) <<< 8);
    end else begin
      filt_sum = (X_W'(fy) <<< 2) + (X_W'(yaw_in) <<< 8);
    end
    filt_mag = filt_sum[X_W-1] ? X_W'(-filt_sum) : X_W'(filt_sum);
    fy_abs   = fy[FILT_W-1] ? FILT_W'(-fy) : FILT_W'(fy);
    fp_abs   = fp[FILT_W-1] ? FILT_W'(-fp) : FILT_W'(fp);
    csx_abs  = csx[STICK_W-1] ? STICK_W'(-csx) : STICK_W'(csx);
    csy_abs  = csy[STICK_W-1] ? STICK_W'(-csy) : STICK_W'(csy);
    // 10 * R - 1.0, the offset rate magnitude scaled by ten.
    t_val    = T_W'({root, 3'b000}) + T_W'({root, 1'b0}) - ONE_T;
    t_abs    = t_val[T_W-1] ? (T_W-1)'(-t_val) : (T_W-1)'(t_val);
    num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dz_term  = (NUM_W'({dz, 4'b0000}) + NUM_W'(dz)) << S;
    mix_x    = MIX_W'(gx) + (dead ? MIX_W'(0) : MIX_W'(csx));
    mix_y    = MIX_W'(gy) + (dead ? MIX_W'(0) : MIX_W'(csy));
    if (mix_x > SAT_HI) begin
      sat_x = SAT_HI[STICK_W-1:0];
    end else if (mix_x < SAT_LO) begin
      sat_x = SAT_LO[STICK_W-1:0];
    end else begin
      sat_x = mix_x[STICK_W-1:0];
    end
    if (mix_y > SAT_HI) begin
      sat_y = SAT_HI[STICK_W-1:0];
    end else if (mix_y < SAT_LO) begin
      sat_y = SAT_LO[STICK_W-1:0];
    end else begin
      sat_y = mix_y[STICK_W-1:0];
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = DIVISOR_W'(FILT_DIV);
    case (state)
      ST_FILT_YAW, ST_FILT_PITCH: begin
        div_n = DIV_W'(filt_mag);
      end
      ST_STICK_X: begin
        mul_a = MUL_A_W'(csx_abs);
        mul_b = MB_W'(csx_abs);
      end
      ST_STICK_Y: begin
        mul_a = MUL_A_W'(csy_abs);
        mul_b = MB_W'(csy_abs);
      end
      ST_DZ: begin
        mul_a = MUL_A_W'(dz);
        mul_b = MB_W'(dz);
      end
      ST_SQ_YAW: begin
        mul_a = fy_abs;
        mul_b = MB_W'(fy_abs);
      end
      ST_SQ_PITCH: begin
        mul_a = fp_abs;
        mul_b = MB_W'(fp_abs);
      end
      ST_NUM: begin
        mul_a = MUL_A_W'(GAIN);
        mul_b = MB_W'(t_abs);
      end
      ST_MAG: begin
        div_n = DIV_W'(num_abs);
        div_d = MAG_DIVISOR;
      end
      ST_GX_MUL: begin
        mul_a = fy_abs;
        mul_b = MB_W'(mag);
      end
      ST_GY_MUL: begin
        mul_a = fp_abs;
        mul_b = MB_W'(mag);
      end
      ST_GX_DIV, ST_GY_DIV: begin
        div_n = mul_p;
        div_d = DIVISOR_W'({root, 8'h00});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: each step that uses a unit launches it once and moves on when it is done.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && op_t'(s_axis_tuser) == OP_TICK) begin
          state_next = ST_FILT_YAW;
        end
      end
      ST_FILT_YAW: begin
        div_start = !launched;
        if (div_stat.done) state_next = ST_FILT_PITCH;
      end
      ST_FILT_PITCH: begin
        div_start = !launched;
        if (div_stat.done) state_next = ST_STICK_X;
      end
      ST_STICK_X: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_STICK_Y;
      end
      ST_STICK_Y: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_DZ;
      end
      ST_DZ: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_SQ_YAW;
      end
      ST_SQ_YAW: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_SQ_PITCH;
      end
      ST_SQ_PITCH: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        sqrt_start = !launched;
        if (sqrt_stat.done) begin
          state_next = (sqrt_root == '0) ? ST_MIX : ST_NUM;
        end
      end
      ST_NUM: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_NUM_ADD;
      end
      ST_NUM_ADD: begin
        state_next = ST_MAG;
      end
      ST_MAG: begin
        div_start = !launched;
        if (div_stat.done) state_next = ST_GX_MUL;
      end
      ST_GX_MUL: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_GX_DIV;
      end
      ST_GX_DIV: begin
        div_start = !launched;
        if (div_stat.done) state_next = ST_GY_MUL;
      end
      ST_GY_MUL: begin
        mul_start = !launched;
        if (mul_stat.done) state_next = ST_GY_DIV;
      end
      ST_GY_DIV: begin
        div_start = !launched;
        if (div_stat.done) state_next = ST_MIX;
      end
      ST_MIX: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DEADZONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fy            <= '0;
      fp            <= '0;
      csx           <= '0;
      csy           <= '0;
      dz            <= '0;
      launched      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_write) dz <= pwdata[DZ_W-1:0];

      if (mul_start || div_start || sqrt_start) begin
        launched <= 1'b1;
      end else if (mul_stat.done || div_stat.done || sqrt_stat.done) begin
        launched <= 1'b0;
      end

      // A finished tick loads the output register once it is free or draining.
      if (state == ST_MIX && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            case (op_t'(s_axis_tuser))
              OP_STICK_X: csx <= s_axis_tdata[15:0];
              OP_STICK_Y: csy <= s_axis_tdata[15:0];
              OP_TICK: begin
                yaw_in   <= s_axis_tdata[31:16];
                pitch_in <= s_axis_tdata[47:32];
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILT_YAW: begin
          if (div_stat.done) begin
            fy <= filt_sum[X_W-1] ? FILT_W'(-div_q) : FILT_W'(div_q);
          end
        end
        ST_FILT_PITCH: begin
          if (div_stat.done) begin
            fp <= filt_sum[X_W-1] ? FILT_W'(-div_q) : FILT_W'(div_q);
          end
        end
        ST_STICK_X: begin
          if (mul_stat.done) sq_sum <= mul_p[31:0];
        end
        ST_STICK_Y: begin
          if (mul_stat.done) sq_sum <= sq_sum + mul_p[31:0];
        end
        ST_DZ: begin
          if (mul_stat.done) dead <= (sq_sum <= mul_p[31:0]);
        end
        ST_SQ_YAW: begin
          if (mul_stat.done) rad <= mul_p[RAD_W-1:0];
        end
        ST_SQ_PITCH: begin
          if (mul_stat.done) rad <= rad + mul_p[RAD_W-1:0];
        end
        ST_SQRT: begin
          if (sqrt_stat.done) begin
            root <= sqrt_root;
            gx   <= '0;
            gy   <= '0;
          end
        end
        ST_NUM: begin
          if (mul_stat.done) begin
            num <= t_val[T_W-1] ? NUM_W'(-mul_p) : NUM_W'(mul_p);
          end
        end
        ST_NUM_ADD: begin
          if (dead) num <= num + dz_term;
        end
        ST_MAG: begin
          if (div_stat.done) begin
            mag     <= div_q[MAG_W-1:0];
            mag_neg <= num[NUM_W-1];
          end
        end
        ST_GX_DIV: begin
          if (div_stat.done) begin
            gx <= (fy[FILT_W-1] ^ mag_neg) ? (MAG_W+1)'(-div_q) : (MAG_W+1)'(div_q);
          end
        end
        ST_GY_DIV: begin
          if (div_stat.done) begin
            gy <= (fp[FILT_W-1] ^ mag_neg) ? (MAG_W+1)'(-div_q) : (MAG_W+1)'(div_q);
          end
        end
        ST_MIX: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {sat_y, sat_x};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEADZONE) ? 32'(dz) : 32'd0;

endmodule

FILE: sv/gsm_mul.sv
// Bit-serial shift-add multiplier, one bit of operand a per cycle.
// Depends on gsm_pkg.
module gsm_mul #(
  parameter int B_W = 29
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gsm_pkg::MUL_A_W-1:0]    a,
  input  logic [B_W-1:0]                 b,
  output gsm_pkg::unit_stat_t            stat,
  output logic [gsm_pkg::MUL_A_W+B_W-1:0] product
);
  import gsm_pkg::*;

  localparam int P_W   = MUL_A_W + B_W;
  localparam int CNT_W = $clog2(MUL_A_W + 1);

  logic [P_W-1:0]   prod;
  logic [B_W-1:0]   mcand;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [B_W:0]     upper_next;

  always_comb begin
    upper_next = {1'b0, prod[P_W-1:MUL_A_W]} + (prod[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_A_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{B_W{1'b0}}, a};
      mcand <= b;
    end else if (busy) begin
      prod <= {upper_next, prod[MUL_A_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = prod;

endmodule

FILE: sv/gsm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gsm_pkg.
module gsm_div #(
  parameter int DD_W = 53
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DD_W-1:0]                 dividend,
  input  logic [gsm_pkg::DIVISOR_W-1:0]   divisor,
  output gsm_pkg::unit_stat_t             stat,
  output logic [DD_W-1:0]                 quotient
);
  import gsm_pkg::*;

  localparam int CNT_W = $clog2(DD_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DD_W-1:0]      quo;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  always_comb begin
    shifted = {rem, quo[DD_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: sv/gsm_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on gsm_pkg.
module gsm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gsm_pkg::RAD_W-1:0]   radicand,
  output gsm_pkg::unit_stat_t         stat,
  output logic [gsm_pkg::ROOT_W-1:0]  root
);
  import gsm_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W-1:0] res;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [ROOT_W+2:0] shifted;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fits;

  always_comb begin
    shifted = {rem, rad[RAD_W-1:RAD_W-2]};
    trial   = {1'b0, res, 2'b01};
    diff    = shifted - trial;
    fits    = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      rem <= fits ? diff[ROOT_W:0] : shifted[ROOT_W:0];
      res <= {res[ROOT_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = res;

endmodule

FILE: sv/gsm_checker.sv
// Port-level checks for the gyro stick mixer, bound to the top level.
// Depends on gsm_pkg and gyro_stick_mixer_unit.
module gsm_props (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import gsm_pkg::*;

  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_deadzone_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_DEADZONE
      |=> prdata == {17'd0, $past(pwdata[14:0])} || paddr[2] != REG_DEADZONE)
    else $error("deadzone readback mismatch");

endmodule

bind gyro_stick_mixer_unit gsm_props u_gsm_props (.*);
